>>> sv/cfbl_pkg.sv
// Shared types and constants for the chained free-block list.
// Holds the command and result codes, register indexes and the queue entry type.
// No dependencies.
package cfbl_pkg;

  localparam int BW                 = 24;  // block number and total width
  localparam int KW                 = 4;   // result kind width
  localparam int CNTW               = 6;   // list count port width
  localparam int DEFAULT_LIST_DEPTH = 32;
  localparam int QUEUE_DEPTH        = 2;

  // configuration register indexes
  localparam logic REG_FIRST_DATA_BLOCK   = 1'b0;
  localparam logic REG_VOLUME_BLOCK_COUNT = 1'b1;

  // command codes
  typedef enum logic [2:0] {
    OP_ALLOC      = 3'd0,
    OP_FREE       = 3'd1,
    OP_LOAD_COUNT = 3'd2,
    OP_LOAD_ENTRY = 3'd3,
    OP_SET_TOTAL  = 3'd4
  } op_e;

  // result kinds
  typedef enum logic [KW-1:0] {
    K_GRANT       = 4'd0,
    K_FREED       = 4'd1,
    K_NO_SPACE    = 4'd2,
    K_BAD_BLOCK   = 4'd3,
    K_NEED_REFILL = 4'd4,
    K_SPILL_COUNT = 4'd5,
    K_SPILL_ENTRY = 4'd6,
    K_LOADED      = 4'd7,
    K_BUSY        = 4'd8
  } kind_e;

  // classified command held in the queue
  typedef struct packed {
    op_e           op;
    logic [BW-1:0] blk;
    logic [BW-1:0] val;
    logic          out_of_range;  // blk outside the data area
    logic          count_bad;     // read error, zero or oversize count
  } cmd_t;

endpackage

>>> sv/cfbl_front.sv
// Front end of the chained free-block list: takes commands, classifies them
// and holds them in a short queue for the back end.
// Depends on cfbl_pkg.
module cfbl_front
  import cfbl_pkg::*;
#(
  parameter int LIST_DEPTH = DEFAULT_LIST_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  logic [2:0]    opcode,
  input  logic [BW-1:0] block_number,
  input  logic [BW-1:0] count_or_total,
  input  logic          read_error,
  input  logic [BW-1:0] first_data_block,
  input  logic [BW-1:0] volume_block_count,
  output cmd_t          cmd,
  output logic          cmd_valid,
  input  logic          cmd_pop
);

  localparam int QAW = $clog2(QUEUE_DEPTH);
  localparam int QFW = $clog2(QUEUE_DEPTH + 1);

  cmd_t             queue [QUEUE_DEPTH];
  logic [QAW-1:0]   wr_ptr;
  logic [QAW-1:0]   rd_ptr;
  logic [QFW-1:0]   fill;
  logic             known;
  logic             push;
  logic             pop;
  cmd_t             incoming;

  // decode and classify the incoming beat
  always_comb begin
    known = 1'b0;
    case (opcode)
      OP_ALLOC, OP_FREE, OP_LOAD_COUNT, OP_LOAD_ENTRY, OP_SET_TOTAL: known = 1'b1;
      default: known = 1'b0;
    endcase
    incoming.op           = op_e'(opcode);
    incoming.blk          = block_number;
    incoming.val          = count_or_total;
    incoming.out_of_range = (block_number < first_data_block) ||
                            (block_number >= volume_block_count);
    incoming.count_bad    = read_error || (count_or_total == '0) ||
                            (count_or_total > BW'(LIST_DEPTH));
  end

  // unknown codes are taken and dropped
  assign busy      = (fill == QFW'(QUEUE_DEPTH));
  assign push      = start && !busy && known;
  assign pop       = cmd_pop && cmd_valid;
  assign cmd_valid = (fill != '0);
  assign cmd       = queue[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= incoming;
    end
  end

  // queue pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QAW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QAW'(1);
      end
      fill <= fill + QFW'(push) - QFW'(pop);
    end
  end

endmodule

>>> sv/cfbl_back.sv
// Back end of the chained free-block list: owns the free stack memory, the
// count, the free total and the refill phase, and issues the result beats.
// Depends on cfbl_pkg.
module cfbl_back
  import cfbl_pkg::*;
#(
  parameter int LIST_DEPTH = DEFAULT_LIST_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  cmd_t            cmd,
  input  logic            cmd_valid,
  output logic            cmd_pop,
  input  logic [BW-1:0]   first_data_block,
  input  logic [BW-1:0]   volume_block_count,
  output logic            result_valid,
  output logic [KW-1:0]   kind,
  output logic [BW-1:0]   result_block,
  output logic [CNTW-1:0] spill_count,
  output logic [CNTW-1:0] list_count,
  output logic [BW-1:0]   total_free,
  output logic            last
);

  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int AW = $clog2(LIST_DEPTH);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SCAN  = 7'b0000010,
    ST_BAD   = 7'b0000100,
    ST_FINAL = 7'b0001000,
    ST_FREE2 = 7'b0010000,
    ST_SPILL = 7'b0100000,
    ST_PUSH0 = 7'b1000000
  } state_t;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_WAIT = 3'b010,
    PH_LOAD = 3'b100
  } phase_t;

  // free stack memory
  logic [BW-1:0] mem [LIST_DEPTH];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [BW-1:0] mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [BW-1:0] rd_data;

  // control state
  state_t        state, state_next;
  phase_t        phase, phase_next;
  logic [CW-1:0] cnt, cnt_next;
  logic [BW-1:0] total, total_next;
  logic [BW-1:0] pending, pending_next;
  logic [CW-1:0] load_idx, load_idx_next;
  logic [CW-1:0] scan, scan_next;
  logic [AW-1:0] ep, ep_next;
  logic [CW-1:0] nbad, nbad_next;
  kind_e         fin_kind, fin_kind_next;
  logic [BW-1:0] fin_blk, fin_blk_next;
  logic [CNTW-1:0] spc, spc_next;
  logic [BW-1:0] held, held_next;

  // beat being issued this cycle
  logic            em_valid;
  kind_e           em_kind;
  logic [BW-1:0]   em_blk;
  logic [CNTW-1:0] em_spc;
  logic            em_last;

  logic [BW-1:0] total_inc;
  logic [BW-1:0] total_dec;
  logic [CW-1:0] cnt_m1;
  logic [CW-1:0] li_inc;
  logic [CW-1:0] nbad_inc;
  logic          rd_oor;

  assign total_inc = (total != '1) ? total + BW'(1) : total;
  assign total_dec = (total != '0) ? total - BW'(1) : total;
  assign cnt_m1    = cnt - CW'(1);
  assign li_inc    = load_idx + CW'(1);
  assign nbad_inc  = nbad + CW'(1);
  assign rd_oor    = (rd_data < first_data_block) || (rd_data >= volume_block_count);

  // sequencer
  always_comb begin
    state_next    = state;
    phase_next    = phase;
    cnt_next      = cnt;
    total_next    = total;
    pending_next  = pending;
    load_idx_next = load_idx;
    scan_next     = scan;
    ep_next       = ep;
    nbad_next     = nbad;
    fin_kind_next = fin_kind;
    fin_blk_next  = fin_blk;
    spc_next      = spc;
    held_next     = held;
    cmd_pop       = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = cmd.blk;
    mem_re        = 1'b0;
    mem_raddr     = '0;
    em_valid      = 1'b0;
    em_kind       = K_BUSY;
    em_blk        = '0;
    em_spc        = '0;
    em_last       = 1'b0;

    case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop  = 1'b1;
          em_valid = 1'b1;
          em_last  = 1'b1;
          case (cmd.op)
            OP_ALLOC: begin
              if (phase != PH_IDLE) begin
                em_kind = K_BUSY;
              end else if (cnt == '0) begin
                cnt_next   = '0;
                total_next = '0;
                em_kind    = K_NO_SPACE;
              end else begin
                // pop the top entry and look at it next cycle
                em_valid   = 1'b0;
                scan_next  = cnt_m1;
                ep_next    = cnt_m1[AW-1:0];
                nbad_next  = '0;
                mem_re     = 1'b1;
                mem_raddr  = cnt_m1[AW-1:0];
                state_next = ST_SCAN;
              end
            end
            OP_FREE: begin
              held_next = cmd.blk;
              if (phase != PH_IDLE) begin
                em_kind = K_BUSY;
              end else if (cmd.out_of_range) begin
                em_kind = K_BAD_BLOCK;
                em_blk  = cmd.blk;
              end else if (cnt == '0) begin
                // end marker goes under the freed block
                em_valid   = 1'b0;
                mem_we     = 1'b1;
                mem_waddr  = '0;
                mem_wdata  = '0;
                state_next = ST_FREE2;
              end else if (cnt >= CW'(LIST_DEPTH)) begin
                // full stack: spill into the freed block
                em_kind    = K_SPILL_COUNT;
                em_blk     = cmd.blk;
                em_spc     = CNTW'(cnt);
                em_last    = 1'b0;
                spc_next   = CNTW'(cnt);
                cnt_next   = CW'(1);
                total_next = total_inc;
                ep_next    = '0;
                mem_re     = 1'b1;
                mem_raddr  = '0;
                state_next = ST_SPILL;
              end else begin
                mem_we     = 1'b1;
                mem_waddr  = cnt[AW-1:0];
                cnt_next   = cnt + CW'(1);
                total_next = total_inc;
                em_kind    = K_FREED;
                em_blk     = cmd.blk;
              end
            end
            OP_LOAD_COUNT: begin
              if (phase != PH_WAIT) begin
                em_kind = K_BUSY;
              end else if (cmd.count_bad) begin
                cnt_next   = '0;
                total_next = '0;
                phase_next = PH_IDLE;
                em_kind    = K_NO_SPACE;
              end else begin
                cnt_next      = cmd.val[CW-1:0];
                load_idx_next = '0;
                phase_next    = PH_LOAD;
                em_kind       = K_LOADED;
                em_blk        = pending;
              end
            end
            OP_LOAD_ENTRY: begin
              if (phase != PH_LOAD) begin
                em_kind = K_BUSY;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = load_idx[AW-1:0];
                if (li_inc >= cnt) begin
                  phase_next    = PH_IDLE;
                  load_idx_next = '0;
                  total_next    = total_dec;
                  em_kind       = K_GRANT;
                  em_blk        = pending;
                end else begin
                  load_idx_next = li_inc;
                  em_kind       = K_LOADED;
                  em_blk        = cmd.blk;
                end
              end
            end
            OP_SET_TOTAL: begin
              if (phase != PH_IDLE) begin
                em_kind = K_BUSY;
              end else begin
                total_next = cmd.val;
                em_kind    = K_LOADED;
              end
            end
            default: begin
              em_valid = 1'b0;
            end
          endcase
        end
      end

      ST_SCAN: begin
        if ((rd_data != '0) && rd_oor && (scan != '0)) begin
          // skip an out-of-range entry and pop the next one
          nbad_next = nbad_inc;
          scan_next = scan - CW'(1);
          mem_re    = 1'b1;
          mem_raddr = scan_next[AW-1:0];
        end else begin
          // outcome known: settle the state first
          if (rd_data == '0 || rd_oor) begin
            cnt_next      = '0;
            total_next    = '0;
            fin_kind_next = K_NO_SPACE;
            fin_blk_next  = '0;
          end else if (scan == '0) begin
            cnt_next      = '0;
            phase_next    = PH_WAIT;
            pending_next  = rd_data;
            load_idx_next = '0;
            fin_kind_next = K_NEED_REFILL;
            fin_blk_next  = rd_data;
          end else begin
            cnt_next      = scan;
            total_next    = total_dec;
            fin_kind_next = K_GRANT;
            fin_blk_next  = rd_data;
          end
          if (rd_data != '0 && rd_oor) begin
            nbad_next = nbad_inc;
          end
          if (nbad_next == '0) begin
            em_valid   = 1'b1;
            em_kind    = fin_kind_next;
            em_blk     = fin_blk_next;
            em_last    = 1'b1;
            state_next = ST_IDLE;
          end else begin
            // replay the skipped entries from the old top
            mem_re     = 1'b1;
            mem_raddr  = ep;
            state_next = ST_BAD;
          end
        end
      end

      ST_BAD: begin
        em_valid = 1'b1;
        em_kind  = K_BAD_BLOCK;
        em_blk   = rd_data;
        if (nbad == CW'(1)) begin
          state_next = ST_FINAL;
        end else begin
          nbad_next = nbad - CW'(1);
          ep_next   = ep - AW'(1);
          mem_re    = 1'b1;
          mem_raddr = ep_next;
        end
      end

      ST_FINAL: begin
        em_valid   = 1'b1;
        em_kind    = fin_kind;
        em_blk     = fin_blk;
        em_last    = 1'b1;
        state_next = ST_IDLE;
      end

      ST_FREE2: begin
        mem_we     = 1'b1;
        mem_waddr  = AW'(1);
        mem_wdata  = held;
        cnt_next   = CW'(2);
        total_next = total_inc;
        em_valid   = 1'b1;
        em_kind    = K_FREED;
        em_blk     = held;
        em_last    = 1'b1;
        state_next = ST_IDLE;
      end

      ST_SPILL: begin
        em_valid = 1'b1;
        em_kind  = K_SPILL_ENTRY;
        em_blk   = rd_data;
        em_spc   = spc;
        if (ep == AW'(LIST_DEPTH - 1)) begin
          state_next = ST_PUSH0;
        end else begin
          ep_next   = ep + AW'(1);
          mem_re    = 1'b1;
          mem_raddr = ep_next;
        end
      end

      ST_PUSH0: begin
        mem_we     = 1'b1;
        mem_waddr  = '0;
        mem_wdata  = held;
        em_valid   = 1'b1;
        em_kind    = K_FREED;
        em_blk     = held;
        em_last    = 1'b1;
        state_next = ST_IDLE;
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // stack memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[mem_raddr];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      phase        <= PH_IDLE;
      cnt          <= '0;
      total        <= '0;
      pending      <= '0;
      load_idx     <= '0;
      nbad         <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      phase        <= phase_next;
      cnt          <= cnt_next;
      total        <= total_next;
      pending      <= pending_next;
      load_idx     <= load_idx_next;
      nbad         <= nbad_next;
      result_valid <= em_valid;
    end
  end

  // working and result payload registers
  always_ff @(posedge clk) begin
    scan         <= scan_next;
    ep           <= ep_next;
    fin_kind     <= fin_kind_next;
    fin_blk      <= fin_blk_next;
    spc          <= spc_next;
    held         <= held_next;
    kind         <= em_kind;
    result_block <= em_blk;
    spill_count  <= em_spc;
    last         <= em_last;
    list_count   <= CNTW'(cnt_next);
    total_free   <= total_next;
  end

endmodule

>>> sv/chained_free_block_list.sv
// Chained free-block list: a stack of free block numbers with a free total.
// Timing: a beat shows in the cycle after its command is taken; an alloc first
// reads the stack top in ST_SCAN, a free onto an empty list passes ST_FREE2; each
// skipped bad entry adds a beat before ST_FINAL; a spill has LIST_DEPTH + 2 beats.
// Throughput: 1 single-beat command per cycle while not busy, 2-entry queue; results cannot stall.
// Sync reset clears config, queue, count, total and phase; stack contents stay unset.
module chained_free_block_list
  import cfbl_pkg::*;
#(
  parameter int LIST_DEPTH = DEFAULT_LIST_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  logic [2:0]      opcode,
  input  logic [BW-1:0]   block_number,
  input  logic [BW-1:0]   count_or_total,
  input  logic            read_error,
  input  logic            cfg_en,
  input  logic            cfg_addr,
  input  logic [BW-1:0]   cfg_data,
  output logic            result_valid,
  output logic [KW-1:0]   kind,
  output logic [BW-1:0]   result_block,
  output logic [CNTW-1:0] spill_count,
  output logic [CNTW-1:0] list_count,
  output logic [BW-1:0]   total_free,
  output logic            last
);

  logic [BW-1:0] first_data_block;
  logic [BW-1:0] volume_block_count;
  cmd_t          cmd;
  logic          cmd_valid;
  logic          cmd_pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      first_data_block   <= '0;
      volume_block_count <= '0;
    end else if (cfg_en) begin
      case (cfg_addr)
        REG_FIRST_DATA_BLOCK:   first_data_block   <= cfg_data;
        REG_VOLUME_BLOCK_COUNT: volume_block_count <= cfg_data;
        default: ;
      endcase
    end
  end

  // command intake and queue
  cfbl_front #(
    .LIST_DEPTH(LIST_DEPTH)
  ) u_front (
    .clk               (clk),
    .rst               (rst),
    .start             (start),
    .busy              (busy),
    .opcode            (opcode),
    .block_number      (block_number),
    .count_or_total    (count_or_total),
    .read_error        (read_error),
    .first_data_block  (first_data_block),
    .volume_block_count(volume_block_count),
    .cmd               (cmd),
    .cmd_valid         (cmd_valid),
    .cmd_pop           (cmd_pop)
  );

  // stack engine
  cfbl_back #(
    .LIST_DEPTH(LIST_DEPTH)
  ) u_back (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .cmd_valid         (cmd_valid),
    .cmd_pop           (cmd_pop),
    .first_data_block  (first_data_block),
    .volume_block_count(volume_block_count),
    .result_valid      (result_valid),
    .kind              (kind),
    .result_block      (result_block),
    .spill_count       (spill_count),
    .list_count        (list_count),
    .total_free        (total_free),
    .last              (last)
  );

endmodule

>>> tb/sv/chained_free_block_list_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the chained free-block list, top chained_free_block_list.
// Needs cfbl_pkg for the command and result codes; a built-in list predictor
// checks every result beat against the beats expected for each accepted command.
module chained_free_block_list_test;
  import cfbl_pkg::*;

  localparam int LIST_DEPTH   = DEFAULT_LIST_DEPTH;
  localparam int DRAIN_CYCLES = 60;
  localparam int END_WAIT     = 4000;

  // opcodes outside the command set, ignored by the block
  localparam logic [2:0] OP_RESERVED_FIRST = 3'd5;
  localparam logic [2:0] OP_RESERVED_LAST  = 3'd7;

  localparam logic [BW-1:0] BLK_MAX = {BW{1'b1}};

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_WAIT_COUNT,
    PH_LOADING
  } list_phase_e;

  typedef struct packed {
    kind_e           kind;
    logic [BW-1:0]   blk;
    logic [CNTW-1:0] spill;
    logic [CNTW-1:0] cnt;
    logic [BW-1:0]   total;
    logic            last;
  } beat_t;

  logic            clk;
  logic            rst;
  logic            start;
  logic            busy;
  logic [2:0]      opcode;
  logic [BW-1:0]   block_number;
  logic [BW-1:0]   count_or_total;
  logic            read_error;
  logic            cfg_en;
  logic            cfg_addr;
  logic [BW-1:0]   cfg_data;
  logic            result_valid;
  logic [KW-1:0]   kind;
  logic [BW-1:0]   result_block;
  logic [CNTW-1:0] spill_count;
  logic [CNTW-1:0] list_count;
  logic [BW-1:0]   total_free;
  logic            last;

  chained_free_block_list #(
    .LIST_DEPTH(LIST_DEPTH)
  ) u_top (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .opcode        (opcode),
    .block_number  (block_number),
    .count_or_total(count_or_total),
    .read_error    (read_error),
    .cfg_en        (cfg_en),
    .cfg_addr      (cfg_addr),
    .cfg_data      (cfg_data),
    .result_valid  (result_valid),
    .kind          (kind),
    .result_block  (result_block),
    .spill_count   (spill_count),
    .list_count    (list_count),
    .total_free    (total_free),
    .last          (last)
  );

  // list predictor state
  logic [BW-1:0] model_stack [0:63];
  int unsigned   model_count;
  logic [BW-1:0] model_total;
  list_phase_e   model_phase;
  logic [BW-1:0] model_chain_blk;
  int unsigned   model_load_pos;
  logic [BW-1:0] model_first_blk;
  logic [BW-1:0] model_end_blk;

  beat_t owed_beats[$];
  beat_t staged_beats[$];
  int    fail_count;
  int    cmds_sent;
  bit    no_gaps;

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("FAIL chained_free_block_list");
    $finish;
  end

  function automatic bit in_data_area(input logic [BW-1:0] b);
    return b >= model_first_blk && b < model_end_blk;
  endfunction

  function automatic void stage_beat(input kind_e k, input logic [BW-1:0] b,
                                     input int unsigned sc);
    beat_t bt;
    bt       = '0;
    bt.kind  = k;
    bt.blk   = b;
    bt.spill = CNTW'(sc);
    staged_beats.push_back(bt);
  endfunction

  function automatic void model_no_space();
    model_count = 0;
    model_total = '0;
    model_phase = PH_IDLE;
    stage_beat(K_NO_SPACE, '0, 0);
  endfunction

  function automatic void model_grant(input logic [BW-1:0] b);
    if (model_total != '0) model_total = model_total - 1'b1;
    stage_beat(K_GRANT, b, 0);
  endfunction

  // work out the beats one accepted command causes and queue them
  function automatic void predict_list_op(input logic [2:0] op_bits, input logic [BW-1:0] bn,
                                          input logic [BW-1:0] cv, input logic err);
    op_e           op;
    logic [BW-1:0] b;
    bit            done;
    int unsigned   c;
    beat_t         bt;
    staged_beats.delete();
    if (op_bits > OP_SET_TOTAL) return;
    op = op_e'(op_bits);
    if (((op == OP_ALLOC || op == OP_FREE || op == OP_SET_TOTAL) && model_phase != PH_IDLE) ||
        (op == OP_LOAD_COUNT && model_phase != PH_WAIT_COUNT) ||
        (op == OP_LOAD_ENTRY && model_phase != PH_LOADING)) begin
      stage_beat(K_BUSY, '0, 0);
    end else begin
      case (op)
        OP_ALLOC: begin
          done = 1'b0;
          while (!done) begin
            if (model_count == 0 || model_count > LIST_DEPTH) begin
              model_no_space();
              done = 1'b1;
            end else begin
              model_count--;
              b = model_stack[model_count];
              if (b == '0) begin
                model_no_space();
                done = 1'b1;
              end else if (!in_data_area(b)) begin
                stage_beat(K_BAD_BLOCK, b, 0);
              end else begin
                // last entry names the next chain block
                if (model_count == 0) begin
                  model_chain_blk = b;
                  model_load_pos  = 0;
                  model_phase     = PH_WAIT_COUNT;
                  stage_beat(K_NEED_REFILL, b, 0);
                end else begin
                  model_grant(b);
                end
                done = 1'b1;
              end
            end
          end
        end
        OP_FREE: begin
          if (!in_data_area(bn)) begin
            stage_beat(K_BAD_BLOCK, bn, 0);
          end else begin
            // empty list gets a zero end marker underneath
            if (model_count == 0) begin
              model_count    = 1;
              model_stack[0] = '0;
            end
            // full list spills into the freed block
            if (model_count >= LIST_DEPTH) begin
              c = model_count;
              stage_beat(K_SPILL_COUNT, bn, c);
              for (int i = 0; i < LIST_DEPTH; i++) stage_beat(K_SPILL_ENTRY, model_stack[i], c);
              model_count = 0;
            end
            model_stack[model_count] = bn;
            model_count++;
            if (model_total != BLK_MAX) model_total = model_total + 1'b1;
            stage_beat(K_FREED, bn, 0);
          end
        end
        OP_LOAD_COUNT: begin
          if (err || cv == '0 || cv > LIST_DEPTH) begin
            model_no_space();
          end else begin
            model_count    = 32'(cv);
            model_load_pos = 0;
            model_phase    = PH_LOADING;
            stage_beat(K_LOADED, model_chain_blk, 0);
          end
        end
        OP_LOAD_ENTRY: begin
          model_stack[model_load_pos] = bn;
          model_load_pos = (model_load_pos + 1) % 64;
          if (model_load_pos >= model_count) begin
            model_phase    = PH_IDLE;
            model_load_pos = 0;
            model_grant(model_chain_blk);
          end else begin
            stage_beat(K_LOADED, bn, 0);
          end
        end
        default: begin
          model_total = cv;
          stage_beat(K_LOADED, '0, 0);
        end
      endcase
    end
    // every beat carries the state after the whole command
    foreach (staged_beats[i]) begin
      bt       = staged_beats[i];
      bt.cnt   = CNTW'(model_count);
      bt.total = model_total;
      bt.last  = (i == staged_beats.size() - 1);
      owed_beats.push_back(bt);
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    beat_t got;
    beat_t exp_beat;
    if (!rst && result_valid) begin
      got = {kind, result_block, spill_count, list_count, total_free, last};
      if (owed_beats.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected beat kind %0d block %0h spill %0d count %0d total %0h last %0b",
                 $time, got.kind, got.blk, got.spill, got.cnt, got.total, got.last);
      end else begin
        exp_beat = owed_beats.pop_front();
        if (got !== exp_beat) begin
          fail_count++;
          $display("%0t: mismatch expected kind %0d block %0h spill %0d count %0d total %0h last %0b",
                   $time, exp_beat.kind, exp_beat.blk, exp_beat.spill, exp_beat.cnt,
                   exp_beat.total, exp_beat.last);
          $display("%0t:          actual   kind %0d block %0h spill %0d count %0d total %0h last %0b",
                   $time, got.kind, got.blk, got.spill, got.cnt, got.total, got.last);
        end
      end
    end
  end

  // send one command beat; start stays high when the next one follows at once
  task automatic issue_cmd(input logic [2:0] op, input logic [BW-1:0] bn,
                           input logic [BW-1:0] cv, input logic err);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(9, 0);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start          <= 1'b1;
    opcode         <= op;
    block_number   <= bn;
    count_or_total <= cv;
    read_error     <= err;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_list_op(op, bn, cv, err);
    if (op <= OP_SET_TOTAL) cmds_sent++;
  endtask

  // drop start and let all owed beats come home
  task automatic settle();
    start <= 1'b0;
    while (owed_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [BW-1:0] val);
    settle();
    cfg_en   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_en <= 1'b0;
    if (idx == REG_FIRST_DATA_BLOCK) model_first_blk = val;
    else model_end_blk = val;
  endtask

  task automatic set_range(input logic [BW-1:0] lo, input logic [BW-1:0] hi);
    write_reg(REG_FIRST_DATA_BLOCK, lo);
    write_reg(REG_VOLUME_BLOCK_COUNT, hi);
  endtask

  // mostly blocks inside the data area, some zero end markers, some anything
  function automatic logic [BW-1:0] pick_block();
    int r;
    r = $urandom_range(99, 0);
    if (r < 80 && model_end_blk > model_first_blk)
      return BW'($urandom_range(model_end_blk - 1, model_first_blk));
    if (r < 85) return '0;
    return BW'($urandom);
  endfunction

  task automatic send_noise();
    issue_cmd(3'($urandom_range(OP_RESERVED_LAST, 0)), pick_block(), BW'($urandom),
              1'($urandom_range(1, 0)));
  endtask

  // chain block count: mostly good, some read errors, zero and oversize counts
  task automatic send_chain_count();
    int               r;
    logic [BW-1:0]    cnt;
    logic             err;
    r   = $urandom_range(99, 0);
    err = 1'b0;
    cnt = BW'($urandom_range(4, 1));
    if (r < 10) err = 1'b1;
    else if (r < 18) cnt = '0;
    else if (r < 26) cnt = BW'($urandom_range(BLK_MAX, LIST_DEPTH + 1));
    else if (r < 36) cnt = BW'(LIST_DEPTH);
    issue_cmd(OP_LOAD_COUNT, pick_block(), cnt, err);
  endtask

  task automatic send_set_total();
    int            r;
    logic [BW-1:0] v;
    r = $urandom_range(3, 0);
    v = (r == 0) ? '0 : (r == 1) ? BLK_MAX : BW'($urandom);
    issue_cmd(OP_SET_TOTAL, pick_block(), v, 1'($urandom_range(1, 0)));
  endtask

  // one short well-formed sequence, or noise, chosen by the list phase
  task automatic run_sequence();
    int r;
    int k;
    no_gaps = ($urandom_range(3, 0) == 0);
    r = $urandom_range(99, 0);
    case (model_phase)
      PH_WAIT_COUNT: begin
        if (r < 85) send_chain_count();
        else send_noise();
      end
      PH_LOADING: begin
        if (r < 90) issue_cmd(OP_LOAD_ENTRY, pick_block(), BW'($urandom), 1'($urandom_range(1, 0)));
        else send_noise();
      end
      default: begin
        if (r < 30) begin
          k = $urandom_range(6, 1);
          repeat (k) issue_cmd(OP_FREE, pick_block(), BW'($urandom), 1'b0);
        end else if (r < 38 && model_end_blk > model_first_blk) begin
          // fill the list, then one more free forces a spill
          while (model_count < LIST_DEPTH)
            issue_cmd(OP_FREE, BW'($urandom_range(model_end_blk - 1, model_first_blk)),
                      BW'($urandom), 1'b0);
          issue_cmd(OP_FREE, BW'($urandom_range(model_end_blk - 1, model_first_blk)),
                    BW'($urandom), 1'b0);
        end else if (r < 75) begin
          k = $urandom_range(6, 1);
          repeat (k) begin
            if (model_phase == PH_IDLE) issue_cmd(OP_ALLOC, pick_block(), BW'($urandom), 1'b0);
          end
        end else if (r < 87) begin
          send_set_total();
        end else begin
          send_noise();
        end
      end
    endcase
  endtask

  // reset values of the registers: every block lies outside the data area
  task automatic test_empty_list();
    no_gaps = 1'b0;
    issue_cmd(OP_ALLOC, '0, '0, 1'b0);
    issue_cmd(OP_FREE, BLK_MAX, '0, 1'b0);
    issue_cmd(OP_FREE, '0, BLK_MAX, 1'b1);
    issue_cmd(OP_RESERVED_FIRST, BLK_MAX, BLK_MAX, 1'b1);
    issue_cmd(OP_RESERVED_LAST, '0, '0, 1'b0);
    issue_cmd(OP_LOAD_COUNT, '0, 24'd3, 1'b0);
    issue_cmd(OP_LOAD_ENTRY, 24'd20, '0, 1'b0);
  endtask

  // range edges, total held at zero on grant and saturated on free
  task automatic test_push_pop_edges();
    set_range(24'd16, 24'd4096);
    issue_cmd(OP_FREE, 24'd16, '0, 1'b0);
    issue_cmd(OP_FREE, 24'd4095, '0, 1'b0);
    issue_cmd(OP_FREE, 24'd15, '0, 1'b0);
    issue_cmd(OP_FREE, 24'd4096, '0, 1'b0);
    issue_cmd(OP_SET_TOTAL, '0, '0, 1'b0);
    issue_cmd(OP_ALLOC, '0, '0, 1'b0);
    issue_cmd(OP_SET_TOTAL, '0, BLK_MAX, 1'b0);
    issue_cmd(OP_FREE, 24'd1000, '0, 1'b0);
    issue_cmd(OP_ALLOC, '0, '0, 1'b0);
    issue_cmd(OP_ALLOC, '0, '0, 1'b0);
    issue_cmd(OP_ALLOC, '0, '0, 1'b0);
  endtask

  // block space from zero up to BLK_MAX - 1 valid: block zero freed acts as an end marker
  task automatic test_full_range();
    set_range('0, BLK_MAX);
    issue_cmd(OP_FREE, '0, '0, 1'b0);
    issue_cmd(OP_FREE, BLK_MAX - 1'b1, '0, 1'b0);
    issue_cmd(OP_FREE, BLK_MAX, '0, 1'b0);
    issue_cmd(OP_ALLOC, '0, '0, 1'b0);
    issue_cmd(OP_ALLOC, '0, '0, 1'b0);
  endtask

  task automatic test_random_traffic(input logic [BW-1:0] lo, input logic [BW-1:0] hi,
                                     input int n_cmds);
    int target;
    set_range(lo, hi);
    target = cmds_sent + n_cmds;
    while (cmds_sent < target) run_sequence();
  endtask

  initial begin
    logic [BW-1:0] lo;
    int            waited;
    rst            <= 1'b1;
    start          <= 1'b0;
    opcode         <= OP_ALLOC;
    block_number   <= '0;
    count_or_total <= '0;
    read_error     <= 1'b0;
    cfg_en         <= 1'b0;
    cfg_addr       <= REG_FIRST_DATA_BLOCK;
    cfg_data       <= '0;
    fail_count      = 0;
    cmds_sent       = 0;
    no_gaps         = 1'b0;
    model_count     = 0;
    model_total     = '0;
    model_phase     = PH_IDLE;
    model_chain_blk = '0;
    model_load_pos  = 0;
    model_first_blk = '0;
    model_end_blk   = '0;
    foreach (model_stack[i]) model_stack[i] = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_list();
    test_push_pop_edges();
    test_full_range();
    test_random_traffic(24'd16, 24'd4096, 100);
    test_random_traffic('0, BLK_MAX, 90);
    test_random_traffic(BLK_MAX - 24'd15, BLK_MAX, 80);
    lo = BW'($urandom_range(24'h7FFFFF, 1));
    test_random_traffic(lo, lo + BW'($urandom_range(5000, 40)), 100);
    test_random_traffic(24'd4096, 24'd16, 30);

    // wait out the last beats
    start <= 1'b0;
    waited = 0;
    while (owed_beats.size() != 0 && waited < END_WAIT) begin
      @(posedge clk);
      waited++;
    end
    if (owed_beats.size() != 0) begin
      fail_count++;
      $display("%0t: %0d beats never arrived", $time, owed_beats.size());
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS chained_free_block_list");
    end else begin
      $display("FAIL chained_free_block_list");
    end
    $finish;
  end

endmodule
